[hdl/ple_pkg.sv]
package ple_pkg;

	localparam int unsigned DATA_W = 32;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;
	localparam logic [1:0] ACT_FIND   = 2'd2;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] found_index;
		logic [6:0] item_count;
	} rsp_t;

endpackage

[hdl/ple_req_if.sv]
interface ple_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] value;
	logic [7:0]  position;

	modport source (output valid, action, value, position, input ready);
	modport sink (input valid, action, value, position, output ready);
endinterface

[hdl/ple_rsp_if.sv]
interface ple_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [5:0] found_index;
	logic [6:0] item_count;

	modport source (output valid, status, found_index, item_count, input ready);
	modport sink (input valid, status, found_index, item_count, output ready);
endinterface

[hdl/ple_store.sv]
module ple_store #(
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [ple_pkg::DATA_W-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic [ple_pkg::DATA_W-1:0] rdata
);

	logic [ple_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/ple_seq.sv]
module ple_seq #(
	parameter int unsigned CAPACITY = 64,
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int unsigned LW = $clog2(CAPACITY + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [1:0]                 action,
	input  logic [31:0]                value,
	input  logic [7:0]                 position,
	output logic                       idle,
	output logic                       res_valid,
	output ple_pkg::rsp_t              res,
	input  logic                       res_ack,
	output logic                       mem_we,
	output logic [AW-1:0]              mem_waddr,
	output logic [ple_pkg::DATA_W-1:0] mem_wdata,
	output logic [AW-1:0]              mem_raddr,
	input  logic [ple_pkg::DATA_W-1:0] mem_rdata
);

	localparam int unsigned CW = (LW > 8) ? LW : 8;
	localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

	state_t                     state_q;
	logic [1:0]                 act_q;
	logic [ple_pkg::DATA_W-1:0] val_q;
	logic [LW-1:0]              len_q;
	logic [LW-1:0]              rem_q;
	logic [AW-1:0]              cur_q;
	logic [AW-1:0]              pos_q;
	logic [AW-1:0]              ra_q;
	logic                       rv_q;
	ple_pkg::rsp_t              res_q;

	logic [CW-1:0] posx;
	logic [CW-1:0] lenx;
	logic [LW-1:0] lm1;
	logic [LW-1:0] ins_p;
	logic [LW-1:0] del_p;
	logic [LW-1:0] del_p1;
	logic [AW-1:0] shift_addr;
	logic          hit;
	logic          issue;
	logic          walk_done;
	logic [LW-1:0] len_nx;
	ple_pkg::rsp_t walk_res;

	always_comb begin
		posx   = CW'(position);
		lenx   = CW'(len_q);
		lm1    = len_q - LW'(1);
		ins_p  = (posx > lenx) ? len_q : posx[LW-1:0];
		del_p  = (posx >= lenx) ? lm1 : posx[LW-1:0];
		del_p1 = del_p + LW'(1);

		shift_addr = (act_q == ple_pkg::ACT_INSERT) ? ra_q + AW'(1) : ra_q - AW'(1);
		hit   = rv_q && (act_q == ple_pkg::ACT_FIND) && (mem_rdata == val_q);
		issue = (state_q == S_WALK) && (rem_q != '0) && !hit;

		mem_raddr = cur_q;
		mem_we    = (state_q == S_WALK) &&
			((rv_q && (act_q != ple_pkg::ACT_FIND)) ||
			 ((act_q == ple_pkg::ACT_INSERT) && (rem_q == '0) && !rv_q));
		mem_waddr = rv_q ? shift_addr : pos_q;
		mem_wdata = rv_q ? mem_rdata : val_q;

		if (act_q == ple_pkg::ACT_FIND) begin
			walk_done = hit || (rem_q == '0);
		end else begin
			walk_done = (rem_q == '0) && !rv_q;
		end

		unique case (act_q)
			ple_pkg::ACT_INSERT: len_nx = len_q + LW'(1);
			ple_pkg::ACT_DELETE: len_nx = lm1;
			default:             len_nx = len_q;
		endcase

		walk_res.status      = ((act_q == ple_pkg::ACT_FIND) && !hit) ?
			ple_pkg::ST_NOTFOUND : ple_pkg::ST_DONE;
		walk_res.found_index = hit ? 6'(ra_q) : 6'd0;
		walk_res.item_count  = 7'(len_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			rem_q   <= '0;
			rv_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						act_q <= action;
						val_q <= value;
						rv_q  <= 1'b0;
						unique case (action)
							ple_pkg::ACT_INSERT: begin
								if (len_q >= CAP_L) begin
									res_q   <= '{ple_pkg::ST_FULL, 6'd0, 7'(len_q)};
									state_q <= S_DONE;
								end else begin
									pos_q   <= ins_p[AW-1:0];
									rem_q   <= len_q - ins_p;
									cur_q   <= lm1[AW-1:0];
									state_q <= S_WALK;
								end
							end
							ple_pkg::ACT_DELETE: begin
								if (len_q == '0) begin
									res_q   <= '{ple_pkg::ST_EMPTY, 6'd0, 7'(len_q)};
									state_q <= S_DONE;
								end else begin
									rem_q   <= lm1 - del_p;
									cur_q   <= del_p1[AW-1:0];
									state_q <= S_WALK;
								end
							end
							ple_pkg::ACT_FIND: begin
								rem_q   <= len_q;
								cur_q   <= '0;
								state_q <= S_WALK;
							end
							default: begin
								res_q   <= '{ple_pkg::ST_DONE, 6'd0, 7'(len_q)};
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_WALK: begin
					rv_q <= issue;
					ra_q <= cur_q;
					if (issue) begin
						rem_q <= rem_q - LW'(1);
						cur_q <= (act_q == ple_pkg::ACT_INSERT) ?
							cur_q - AW'(1) : cur_q + AW'(1);
					end
					if (walk_done) begin
						len_q   <= len_nx;
						res_q   <= walk_res;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ack) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CAP_L)
		else $error("list length above capacity");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_WALK |-> !mem_we)
		else $error("store written outside a walk");

	a_no_read_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_WALK |-> !rv_q)
		else $error("read data pending outside a walk");

	a_issue_tag: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> rv_q && (ra_q == $past(cur_q)))
		else $error("read tag lost");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_q.status == ple_pkg::ST_FULL) |-> len_q == CAP_L)
		else $error("full status with room left");

endmodule

[hdl/positional_list_engine_core.sv]
// Channel  Dir  Payload                               Handshake
// req      in   action, value, position               valid/ready
// rsp      out  status, found_index, item_count       valid/ready
//
// Insert or delete walks over the m entries that it moves; find walks up to a match at
// index i, or over the whole length on a miss. Each item also passes the idle and the
// result state; full, empty and unused codes take only those states and no walk.
// Reset clears the length; the store is not cleared.
// req.ready is high only while the sequencer is idle; a result waits in the output
// register while the next item is taken, and a finished result holds the sequencer.
module positional_list_engine_core #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	ple_req_if.sink    req,
	ple_rsp_if.source  rsp
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic                       idle;
	logic                       res_valid;
	ple_pkg::rsp_t              res;
	logic                       res_ack;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [ple_pkg::DATA_W-1:0] mem_wdata;
	logic [AW-1:0]              mem_raddr;
	logic [ple_pkg::DATA_W-1:0] mem_rdata;
	logic                       ov_q;
	ple_pkg::rsp_t              out_q;

	ple_seq #(.CAPACITY(CAPACITY)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req.valid && idle),
		.action    (req.action),
		.value     (req.value),
		.position  (req.position),
		.idle      (idle),
		.res_valid (res_valid),
		.res       (res),
		.res_ack   (res_ack),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ple_store #(.DEPTH(CAPACITY)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign req.ready = idle;
	assign res_ack   = res_valid && (!ov_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else begin
			if (res_ack) begin
				ov_q  <= 1'b1;
				out_q <= res;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.status      = out_q.status;
	assign rsp.found_index = out_q.found_index;
	assign rsp.item_count  = out_q.item_count;

endmodule

[tb/tb_positional_list_engine_core.sv]
module tb_positional_list_engine_core;

	localparam int LIST_DEPTH = 64;
	localparam int RANDOM_ITEMS = 600;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 80;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]    act;
		logic [31:0]   val;
		logic [7:0]    pos;
		bit            fixed;
		ple_pkg::rsp_t want;
	} step_row_t;

	logic clk;
	logic arst_n;
	bit   steady;
	int   mismatches;
	int   stall_cycles;

	logic [31:0]   mirror_items [LIST_DEPTH];
	int            mirror_len;
	ple_pkg::rsp_t pending_rsp [$];
	step_row_t     directed_rows [$];
	ple_pkg::rsp_t head_rsp;

	ple_req_if req_ch ();
	ple_rsp_if rsp_ch ();

	positional_list_engine_core #(
		.CAPACITY(LIST_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic ple_pkg::rsp_t apply_request(input logic [1:0] act,
			input logic [31:0] val, input logic [7:0] pos);
		ple_pkg::rsp_t r;
		int   p;
		int   i;
		bit   hit;
		r.status = ple_pkg::ST_DONE;
		r.found_index = '0;
		hit = 1'b0;
		case (act)
			ple_pkg::ACT_INSERT: begin
				if (mirror_len >= LIST_DEPTH) begin
					r.status = ple_pkg::ST_FULL;
				end else begin
					p = (int'(pos) > mirror_len) ? mirror_len : int'(pos);
					for (i = mirror_len; i > p; i--)
						mirror_items[i] = mirror_items[i - 1];
					mirror_items[p] = val;
					mirror_len++;
				end
			end
			ple_pkg::ACT_DELETE: begin
				if (mirror_len == 0) begin
					r.status = ple_pkg::ST_EMPTY;
				end else begin
					p = (int'(pos) >= mirror_len) ? mirror_len - 1 : int'(pos);
					for (i = p; i + 1 < mirror_len; i++)
						mirror_items[i] = mirror_items[i + 1];
					mirror_len--;
				end
			end
			ple_pkg::ACT_FIND: begin
				for (i = 0; i < mirror_len; i++) begin
					if (!hit && mirror_items[i] == val) begin
						hit = 1'b1;
						r.found_index = 6'(i);
					end
				end
				if (!hit)
					r.status = ple_pkg::ST_NOTFOUND;
			end
			default: begin
			end
		endcase
		r.item_count = 7'(mirror_len);
		return r;
	endfunction

	function automatic void add_row(input logic [1:0] act, input logic [31:0] val,
			input logic [7:0] pos, input bit fixed, input logic [1:0] st,
			input logic [5:0] idx, input logic [6:0] cnt);
		step_row_t row;
		row.act = act;
		row.val = val;
		row.pos = pos;
		row.fixed = fixed;
		row.want.status = st;
		row.want.found_index = idx;
		row.want.item_count = cnt;
		directed_rows.push_back(row);
	endfunction

	task automatic push_request(input logic [1:0] act, input logic [31:0] val,
			input logic [7:0] pos, input bit fixed, input ple_pkg::rsp_t want);
		ple_pkg::rsp_t predicted;
		while (!steady && $urandom_range(99) < 6) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.value <= val;
		req_ch.position <= pos;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predicted = apply_request(act, val, pos);
		pending_rsp.push_back(fixed ? want : predicted);
	endtask

	always @(posedge clk) begin
		rsp_ch.ready <= steady || ($urandom_range(99) >= 6);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				$display("%0t unexpected item: expected none, got status %0d index %0d count %0d",
					$time, rsp_ch.status, rsp_ch.found_index, rsp_ch.item_count);
			end else begin
				head_rsp = pending_rsp.pop_front();
				if (rsp_ch.status !== head_rsp.status) begin
					mismatches++;
					$display("%0t status: expected %0d, got %0d",
						$time, head_rsp.status, rsp_ch.status);
				end
				if (rsp_ch.found_index !== head_rsp.found_index) begin
					mismatches++;
					$display("%0t found_index: expected %0d, got %0d",
						$time, head_rsp.found_index, rsp_ch.found_index);
				end
				if (rsp_ch.item_count !== head_rsp.item_count) begin
					mismatches++;
					$display("%0t item_count: expected %0d, got %0d",
						$time, head_rsp.item_count, rsp_ch.item_count);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		logic [1:0]  act;
		logic [31:0] val;
		logic [7:0]  pos;
		int          roll;
		bit          grow;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ple_pkg::ACT_INSERT;
		req_ch.value = '0;
		req_ch.position = '0;
		rsp_ch.ready = 1'b0;
		steady = 1'b0;
		mismatches = 0;
		stall_cycles = 0;
		mirror_len = 0;

		add_row(ple_pkg::ACT_DELETE, 32'h0000_0000, 8'd0,   1'b1, ple_pkg::ST_EMPTY,
			6'd0, 7'd0);
		add_row(ple_pkg::ACT_FIND,   32'h0000_0000, 8'd0,   1'b1, ple_pkg::ST_NOTFOUND,
			6'd0, 7'd0);
		add_row(ACT_UNUSED,          32'hFFFF_FFFF, 8'd255, 1'b1, ple_pkg::ST_DONE,
			6'd0, 7'd0);
		add_row(ple_pkg::ACT_INSERT, 32'h0000_0000, 8'd255, 1'b1, ple_pkg::ST_DONE,
			6'd0, 7'd1);
		add_row(ple_pkg::ACT_INSERT, 32'hFFFF_FFFF, 8'd0,   1'b1, ple_pkg::ST_DONE,
			6'd0, 7'd2);
		add_row(ple_pkg::ACT_FIND,   32'h0000_0000, 8'd0,   1'b1, ple_pkg::ST_DONE,
			6'd1, 7'd2);
		add_row(ple_pkg::ACT_FIND,   32'hFFFF_FFFF, 8'd0,   1'b1, ple_pkg::ST_DONE,
			6'd0, 7'd2);
		add_row(ple_pkg::ACT_INSERT, 32'h8000_0001, 8'd1,   1'b0, ple_pkg::ST_DONE,
			6'd0, 7'd0);
		add_row(ple_pkg::ACT_INSERT, 32'h1234_5678, 8'd3,   1'b0, ple_pkg::ST_DONE,
			6'd0, 7'd0);
		add_row(ple_pkg::ACT_INSERT, 32'h0000_0000, 8'd2,   1'b0, ple_pkg::ST_DONE,
			6'd0, 7'd0);
		add_row(ple_pkg::ACT_FIND,   32'h0000_0000, 8'd0,   1'b0, ple_pkg::ST_DONE,
			6'd0, 7'd0);
		add_row(ple_pkg::ACT_FIND,   32'h5555_AAAA, 8'd0,   1'b1, ple_pkg::ST_NOTFOUND,
			6'd0, 7'd5);
		add_row(ACT_UNUSED,          32'h0000_0000, 8'd0,   1'b0, ple_pkg::ST_DONE,
			6'd0, 7'd0);
		add_row(ple_pkg::ACT_DELETE, 32'h0000_0000, 8'd255, 1'b0, ple_pkg::ST_DONE,
			6'd0, 7'd0);
		add_row(ple_pkg::ACT_DELETE, 32'hFFFF_FFFF, 8'd4,   1'b0, ple_pkg::ST_DONE,
			6'd0, 7'd0);
		add_row(ple_pkg::ACT_DELETE, 32'h0000_0000, 8'd0,   1'b0, ple_pkg::ST_DONE,
			6'd0, 7'd0);
		add_row(ple_pkg::ACT_FIND,   32'h8000_0001, 8'd77,  1'b0, ple_pkg::ST_DONE,
			6'd0, 7'd0);
		add_row(ple_pkg::ACT_INSERT, 32'hAAAA_5555, 8'd128, 1'b0, ple_pkg::ST_DONE,
			6'd0, 7'd0);
		add_row(ple_pkg::ACT_FIND,   32'hAAAA_5555, 8'd0,   1'b0, ple_pkg::ST_DONE,
			6'd0, 7'd0);
		add_row(ple_pkg::ACT_DELETE, 32'h0000_0000, 8'd1,   1'b0, ple_pkg::ST_DONE,
			6'd0, 7'd0);
		add_row(ple_pkg::ACT_DELETE, 32'h0000_0000, 8'd0,   1'b0, ple_pkg::ST_DONE,
			6'd0, 7'd0);
		add_row(ple_pkg::ACT_DELETE, 32'h0000_0000, 8'd7,   1'b0, ple_pkg::ST_DONE,
			6'd0, 7'd0);
		add_row(ple_pkg::ACT_DELETE, 32'h0000_0000, 8'd0,   1'b1, ple_pkg::ST_EMPTY,
			6'd0, 7'd0);
		add_row(ple_pkg::ACT_FIND,   32'hAAAA_5555, 8'd0,   1'b1, ple_pkg::ST_NOTFOUND,
			6'd0, 7'd0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k])
			push_request(directed_rows[k].act, directed_rows[k].val, directed_rows[k].pos,
				directed_rows[k].fixed, directed_rows[k].want);

		// alternate fill and drain phases so both full and empty are hit repeatedly
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			grow = ((n / 150) % 2) == 0;
			steady = (n >= 300 && n < 420);
			roll = $urandom_range(99);
			if (roll < 3)
				act = ACT_UNUSED;
			else if (roll < (grow ? 70 : 18))
				act = ple_pkg::ACT_INSERT;
			else if (roll < 85)
				act = ple_pkg::ACT_DELETE;
			else
				act = ple_pkg::ACT_FIND;
			if ($urandom_range(3) == 0)
				val = $urandom_range(7);
			else
				val = $urandom();
			if (act == ple_pkg::ACT_FIND && mirror_len > 0 && $urandom_range(99) < 65)
				val = mirror_items[$urandom_range(mirror_len - 1)];
			roll = $urandom_range(9);
			if (roll < 7)
				pos = 8'($urandom_range(mirror_len));
			else if (roll < 9)
				pos = 8'($urandom_range(255));
			else
				pos = 8'hFF;
			push_request(act, val, pos, 1'b0, '0);
		end
		steady = 1'b0;
		req_ch.valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
